// ----- rtl/bnthin_pkg.sv -----
// Package for the binary thinning iteration unit: codes, limits, shared types
// and the per-pixel deletion rule of one thinning sub-pass.
// No dependencies.
`default_nettype none

package bnthin_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int NEIGH_LIMIT   = 7;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int FRAME_W_BITS = 11;
    localparam int FRAME_H_BITS = 13;
    localparam int ROW_BITS     = 14;
    localparam int LINE_BITS    = 2;

    localparam logic [FRAME_W_BITS-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [FRAME_H_BITS-1:0] RST_FRAME_HEIGHT = 13'd768;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic RULE_FIRST  = 1'b0;
    localparam logic RULE_SECOND = 1'b1;

    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } t_edge_mask;

    typedef struct packed {
        logic       pix;
        logic       out_v;
        logic       last;
        t_edge_mask mask1;
        t_edge_mask mask2;
    } t_stage_flags;

    // ring[0..7] = N, NE, E, SE, S, SW, W, NW
    function automatic logic thin_cell(input logic center, input logic [7:0] ring,
                                       input logic rule);
        logic [7:0] rise;
        logic [3:0] b;
        logic [3:0] a;
        logic       guard;
        logic       del;
        rise = ~ring & {ring[0], ring[7:1]};
        b = '0;
        a = '0;
        for (int i = 0; i < 8; i++) begin
            b = b + 4'(ring[i]);
            a = a + 4'(rise[i]);
        end
        if (rule == RULE_SECOND) begin
            guard = (ring[0] & ring[2] & ring[6]) | (ring[0] & ring[4] & ring[6]);
        end else begin
            guard = (ring[0] & ring[2] & ring[4]) | (ring[2] & ring[4] & ring[6]);
        end
        del = (b >= 4'd2) && (b < 4'(NEIGH_LIMIT)) && (a == 4'd1) && !guard;
        return center && !del;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bnthin_if.sv -----
// Stream channel interfaces of the binary thinning iteration unit:
// pixel input beats and thinned pixel output beats. No dependencies.
`default_nettype none

interface bnthin_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic pixel_in;

    modport source (output valid, output operation, output pixel_in, input ready);
    modport sink   (input valid, input operation, input pixel_in, output ready);
endinterface

interface bnthin_out_if;
    logic valid;
    logic ready;
    logic pixel_out;
    logic frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/bnthin_line_buf.sv -----
// Line store: one 2-bit column entry per pixel column, registered read,
// forwarding of a same-cycle write to the read port. Uses bnthin_pkg.
`default_nettype none

module bnthin_line_buf
    import bnthin_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [LINE_BITS-1:0] i_wr_data,
    output logic [LINE_BITS-1:0] o_rd_data
);

    logic [LINE_BITS-1:0] mem [DEPTH];
    logic [LINE_BITS-1:0] r_rd;
    logic [LINE_BITS-1:0] r_byp_data;
    logic                 r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd       <= mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd;

endmodule

`default_nettype wire

// ----- rtl/bnthin_window.sv -----
// 3x3 window of one sub-pass: two stored columns plus the incoming column,
// edge masking, center and ring out. Uses bnthin_pkg.
`default_nettype none

module bnthin_window
    import bnthin_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [2:0] i_col,
    input  t_edge_mask i_mask,
    output logic       o_center,
    output logic [7:0] o_ring
);

    // column bits: [2] row above, [1] center row, [0] row below
    logic [2:0] r_mid;
    logic [2:0] r_left;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_left <= r_mid;
            r_mid  <= i_col;
        end
    end

    assign o_center  = r_mid[1];
    assign o_ring[0] = r_mid[2] & i_mask.top;
    assign o_ring[1] = i_col[2] & i_mask.top & i_mask.right;
    assign o_ring[2] = i_col[1] & i_mask.right;
    assign o_ring[3] = i_col[0] & i_mask.bot & i_mask.right;
    assign o_ring[4] = r_mid[0] & i_mask.bot;
    assign o_ring[5] = r_left[0] & i_mask.bot & i_mask.left;
    assign o_ring[6] = r_left[1] & i_mask.left;
    assign o_ring[7] = r_left[2] & i_mask.top & i_mask.left;

endmodule

`default_nettype wire

// ----- rtl/binary_thinning_iteration_unit.sv -----
// Top level of the binary thinning iteration unit: position tracking, stage
// register, two window passes with their line stores, output register.
// Uses bnthin_pkg, bnthin_if, bnthin_line_buf and bnthin_window.
`default_nettype none

// Takes one binary pixel beat per cycle in raster order, unless the output
// stalls, and returns one full thinning iteration (both sub-passes) one pixel
// per beat. The result for a pixel leaves with the input beat that comes
// 2*W+2 beats after it (W = row width), so each frame is followed by exactly
// 2*W+2 drain beats; results pass through the stage and output registers. The
// input rate is set by the single-port write plus registered read of each of
// the two MAX_WIDTH x 2-bit line stores. No clearing pass after reset: edge
// masking keeps stale line contents out of every decision. A register write
// restarts the frame and must be made while the block is idle.
module binary_thinning_iteration_unit
    import bnthin_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bnthin_in_if.sink             i_pix,
    bnthin_out_if.source          o_pix
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = ROW_BITS;

    logic [FRAME_W_BITS-1:0] r_frame_width;
    logic [FRAME_H_BITS-1:0] r_frame_height;
    logic [WW-1:0]           w_eff;
    logic [WW-1:0]           w_last;
    logic [FRAME_H_BITS-1:0] h_eff;
    logic [FRAME_H_BITS-1:0] h_last;
    logic signed [RW-1:0]    h_s;
    logic signed [RW-1:0]    hl_s;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = FRAME_H_BITS'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_eff = FRAME_H_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    assign w_last = w_eff - WW'(1);
    assign h_last = h_eff - FRAME_H_BITS'(1);
    assign h_s    = $signed({1'b0, h_eff});
    assign hl_s   = $signed({1'b0, h_last});

    // position trackers: incoming beat (t), pass-one center (q), output (m)
    logic                    r_fresh;
    logic                    r_done;
    logic [CW-1:0]           r_t_col, r_q_col, r_m_col;
    logic [FRAME_H_BITS-2:0] r_t_row;
    logic signed [RW-1:0]    r_q_row, r_m_row;

    logic                    cur_done;
    logic [CW-1:0]           cur_t_col, cur_q_col, cur_m_col;
    logic [FRAME_H_BITS-2:0] cur_t_row;
    logic signed [RW-1:0]    cur_q_row, cur_m_row;

    always_comb begin
        if (r_fresh) begin
            cur_done  = 1'b0;
            cur_t_col = '0;
            cur_t_row = '0;
            cur_q_col = CW'(w_last);
            cur_q_row = RW'(-2);
            if (w_eff == WW'(1)) begin
                cur_m_col = '0;
                cur_m_row = RW'(-4);
            end else begin
                cur_m_col = CW'(w_eff - WW'(2));
                cur_m_row = RW'(-3);
            end
        end else begin
            cur_done  = r_done;
            cur_t_col = r_t_col;
            cur_t_row = r_t_row;
            cur_q_col = r_q_col;
            cur_q_row = r_q_row;
            cur_m_col = r_m_col;
            cur_m_row = r_m_row;
        end
    end

    logic w_accept, w_step, w_fire;
    logic t_wrap, q_wrap, m_wrap, m_last, m_out;
    logic                    n_done;
    logic [CW-1:0]           n_t_col, n_q_col, n_m_col;
    logic [FRAME_H_BITS-2:0] n_t_row;
    logic signed [RW-1:0]    n_q_row, n_m_row;
    t_edge_mask              mask1, mask2;

    assign w_accept = i_pix.valid && i_pix.ready;
    assign w_step   = w_accept && ((i_pix.operation == OP_DRAIN) ? cur_done : !cur_done);

    always_comb begin
        t_wrap  = (WW'(cur_t_col) == w_last);
        q_wrap  = (WW'(cur_q_col) == w_last);
        m_wrap  = (WW'(cur_m_col) == w_last);
        n_t_col = t_wrap ? '0 : cur_t_col + CW'(1);
        n_q_col = q_wrap ? '0 : cur_q_col + CW'(1);
        n_m_col = m_wrap ? '0 : cur_m_col + CW'(1);
        n_q_row = q_wrap ? cur_q_row + RW'(1) : cur_q_row;
        n_m_row = m_wrap ? cur_m_row + RW'(1) : cur_m_row;
        n_t_row = cur_t_row;
        n_done  = cur_done;
        if (t_wrap) begin
            if ({1'b0, cur_t_row} == h_last) begin
                n_t_row = '0;
                n_done  = 1'b1;
            end else begin
                n_t_row = cur_t_row + (FRAME_H_BITS - 1)'(1);
            end
        end
        m_last = m_wrap && (cur_m_row == hl_s);
        m_out  = !cur_m_row[RW-1] && (cur_m_row < h_s);
        mask1.top   = !cur_q_row[RW-1] && (cur_q_row != '0);
        mask1.bot   = cur_q_row < hl_s;
        mask1.left  = cur_q_col != '0;
        mask1.right = !q_wrap;
        mask2.top   = !cur_m_row[RW-1] && (cur_m_row != '0);
        mask2.bot   = cur_m_row < hl_s;
        mask2.left  = cur_m_col != '0;
        mask2.right = !m_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_fresh        <= 1'b1;
            r_done         <= 1'b0;
            r_t_col        <= '0;
            r_t_row        <= '0;
            r_q_col        <= '0;
            r_q_row        <= '0;
            r_m_col        <= '0;
            r_m_row        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[FRAME_W_BITS-1:0];
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[FRAME_H_BITS-1:0];
                end
                default: begin
                end
            endcase
            r_fresh <= 1'b1;
            r_done  <= 1'b0;
        end else if (w_step) begin
            r_fresh <= m_last;
            r_done  <= m_last ? 1'b0 : n_done;
            r_t_col <= n_t_col;
            r_t_row <= n_t_row;
            r_q_col <= n_q_col;
            r_q_row <= n_q_row;
            r_m_col <= n_m_col;
            r_m_row <= n_m_row;
        end
    end

    // stage register
    logic          r_v;
    t_stage_flags  r_fl;
    logic [CW-1:0] r_st_tcol;
    logic [CW-1:0] r_st_qcol;
    logic          r_out_v;
    logic          r_out_pix;
    logic          r_out_last;

    assign w_fire      = r_v && (!r_fl.out_v || !r_out_v || o_pix.ready);
    assign i_pix.ready = !r_v || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_step) begin
            r_v <= 1'b1;
        end else if (w_fire) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_fl.pix   <= i_pix.pixel_in;
            r_fl.out_v <= m_out;
            r_fl.last  <= m_last;
            r_fl.mask1 <= mask1;
            r_fl.mask2 <= mask2;
            r_st_tcol  <= cur_t_col;
            r_st_qcol  <= cur_q_col;
        end
    end

    // pass one over input pixels, pass two over pass-one results
    logic [LINE_BITS-1:0] rd1, rd2;
    logic                 c1, c2, y1, res;
    logic [7:0]           ring1, ring2;

    bnthin_line_buf #(.DEPTH(MAX_WIDTH)) u_lb1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_step),
        .i_rd_addr (cur_t_col),
        .i_wr_en   (w_fire),
        .i_wr_addr (r_st_tcol),
        .i_wr_data ({r_fl.pix, rd1[1]}),
        .o_rd_data (rd1)
    );

    bnthin_window u_win1 (
        .i_clk    (i_clk),
        .i_shift  (w_fire),
        .i_col    ({rd1[0], rd1[1], r_fl.pix}),
        .i_mask   (r_fl.mask1),
        .o_center (c1),
        .o_ring   (ring1)
    );

    assign y1 = thin_cell(c1, ring1, RULE_FIRST);

    bnthin_line_buf #(.DEPTH(MAX_WIDTH)) u_lb2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_step),
        .i_rd_addr (cur_q_col),
        .i_wr_en   (w_fire),
        .i_wr_addr (r_st_qcol),
        .i_wr_data ({y1, rd2[1]}),
        .o_rd_data (rd2)
    );

    bnthin_window u_win2 (
        .i_clk    (i_clk),
        .i_shift  (w_fire),
        .i_col    ({rd2[0], rd2[1], y1}),
        .i_mask   (r_fl.mask2),
        .o_center (c2),
        .o_ring   (ring2)
    );

    assign res = thin_cell(c2, ring2, RULE_SECOND);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_fire && r_fl.out_v) begin
            r_out_v <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_fl.out_v) begin
            r_out_pix  <= res;
            r_out_last <= r_fl.last;
        end
    end

    assign o_pix.valid      = r_out_v;
    assign o_pix.pixel_out  = r_out_pix;
    assign o_pix.frame_last = r_out_last;

`ifndef NO_ASSERTIONS
    a_fresh_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh |-> !r_done)
        else $error("frame restart left the input-done flag set");

    a_out_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fresh |-> (r_m_row < h_s))
        else $error("output row ran past the frame height");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_fl.out_v) |=> r_out_v)
        else $error("result beat lost at the output register");
`endif

endmodule

`default_nettype wire
